// ===== src/sbd_pkg.sv =====
package sbd_pkg;

  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned LEN_W              = 7;
  localparam int unsigned BUFFER_DEPTH_DEF   = 64;
  localparam int unsigned RESULT_CAP         = 64;

  localparam logic [BYTE_W-1:0] START_BYTE     = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE       = 8'h03;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic frame_clr;   // stx seen, restart check and fill
    logic body_acc;    // fold input word into block check
    logic body_store;  // write input word to payload store
    logic ld_error;    // load mismatch result
    logic ld_empty;    // load empty-frame result
    logic emit_init;   // latch delivered length, rewind read index
    logic emit_byte;   // read one stored word into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_stx;
    logic is_etx;
    logic chk_ok;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/stx_etx_bcc_deframer.sv =====
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ---------------------------------
// in        input      in_valid_i / in_stall_o   rx_byte_i
// out       output     out_valid_o / out_stall_i payload_byte_o, has_data_o,
//                                                status_o, payload_length_o, last_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_max_length_i
//
// a received word is accepted without stall while hunting or inside a frame
// after a matching check word the frame is sent one word per cycle from the
// payload store read port while the output is not stalled
// input stalls during delivery and, on the check word, until the output register is free
// reset clears control and output state; the payload store and read register are not cleared
// cfg_ready_o is always high; max_length resets to 64
module stx_etx_bcc_deframer #(
  parameter int unsigned BUFFER_DEPTH = sbd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sbd_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [sbd_pkg::BYTE_W-1:0] payload_byte_o,
  output logic                       has_data_o,
  output logic                       status_o,
  output logic [sbd_pkg::LEN_W-1:0]  payload_length_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sbd_pkg::LEN_W-1:0]  cfg_max_length_i
);

  sbd_pkg::cmd_t cmd;
  sbd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbd_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_byte_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_max_length_i (cfg_max_length_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_byte_o   (payload_byte_o),
    .has_data_o       (has_data_o),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .last_o           (last_o)
  );

endmodule

// ===== src/sbd_ctrl.sv =====
module sbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sbd_pkg::sts_t sts_i,
  output sbd_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_BODY,
    ST_CHECK,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  always_comb begin
    unique case (state_q)
      ST_CHECK: in_stall_o = !sts_i.out_free;
      ST_EMIT:  in_stall_o = 1'b1;
      default:  in_stall_o = 1'b0;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (in_acc && sts_i.is_stx) begin
          cmd_o.frame_clr = 1'b1;
          state_d         = ST_BODY;
        end
      end
      ST_BODY: begin
        if (in_acc) begin
          cmd_o.body_acc = 1'b1;
          if (sts_i.is_etx) begin
            state_d = ST_CHECK;
          end else begin
            cmd_o.body_store = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (in_acc) begin
          priority if (!sts_i.chk_ok) begin
            cmd_o.ld_error = 1'b1;
            state_d        = ST_HUNT;
          end else if (sts_i.len_zero) begin
            cmd_o.ld_empty = 1'b1;
            state_d        = ST_HUNT;
          end else begin
            cmd_o.emit_init = 1'b1;
            state_d         = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_HUNT;
          end
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/sbd_dpath.sv =====
module sbd_dpath #(
  parameter int unsigned BUFFER_DEPTH = sbd_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [sbd_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic                           cfg_valid_i,
  input  logic [sbd_pkg::LEN_W-1:0]      cfg_max_length_i,
  input  sbd_pkg::cmd_t                  cmd_i,
  output sbd_pkg::sts_t                  sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sbd_pkg::BYTE_W-1:0]     payload_byte_o,
  output logic                           has_data_o,
  output logic                           status_o,
  output logic [sbd_pkg::LEN_W-1:0]      payload_length_o,
  output logic                           last_o
);

  localparam int unsigned BW    = sbd_pkg::BYTE_W;
  localparam int unsigned LW    = sbd_pkg::LEN_W;
  localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned ADR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CMP_W = (CNT_W > LW) ? CNT_W : LW;

  logic [BW-1:0]    mem [BUFFER_DEPTH];
  logic [BW-1:0]    acc_q;
  logic [CNT_W-1:0] stored_q;
  logic [LW-1:0]    max_len_q;
  logic [LW-1:0]    len_q;
  logic [LW-1:0]    idx_q;
  logic [BW-1:0]    rd_q;
  logic             out_valid_q;
  logic             has_data_q;
  logic             status_q;
  logic             last_q;
  logic [LW-1:0]    out_len_q;

  logic [CMP_W-1:0] sc_ext, ml_ext, cap_ext, min_a, min_b;
  logic [LW-1:0]    len_calc;
  logic             room;
  logic             out_free;

  // delivered length: stored words, limited by max_length and the result cap
  assign sc_ext   = CMP_W'(stored_q);
  assign ml_ext   = CMP_W'(max_len_q);
  assign cap_ext  = CMP_W'(sbd_pkg::RESULT_CAP);
  assign min_a    = (sc_ext < ml_ext) ? sc_ext : ml_ext;
  assign min_b    = (min_a < cap_ext) ? min_a : cap_ext;
  assign len_calc = LW'(min_b);

  assign room     = stored_q < CNT_W'(BUFFER_DEPTH);
  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.is_stx   = rx_byte_i == sbd_pkg::START_BYTE;
  assign sts_o.is_etx   = rx_byte_i == sbd_pkg::END_BYTE;
  assign sts_o.chk_ok   = rx_byte_i == acc_q;
  assign sts_o.len_zero = len_calc == '0;
  assign sts_o.idx_last = idx_q == (len_q - LW'(1));
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sbd_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_max_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      stored_q <= '0;
    end else if (cmd_i.frame_clr) begin
      acc_q    <= '0;
      stored_q <= '0;
    end else begin
      if (cmd_i.body_acc) begin
        acc_q <= acc_q ^ rx_byte_i;
      end
      if (cmd_i.body_store && room) begin
        stored_q <= stored_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.body_store && room) begin
      mem[ADR_W'(stored_q)] <= rx_byte_i;
    end
  end

  // memory read register doubles as the output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_byte) begin
      rd_q <= mem[ADR_W'(idx_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else if (cmd_i.emit_init) begin
      len_q <= len_calc;
      idx_q <= '0;
    end else if (cmd_i.emit_byte) begin
      idx_q <= idx_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      has_data_q  <= 1'b0;
      status_q    <= 1'b0;
      last_q      <= 1'b0;
      out_len_q   <= '0;
    end else if (cmd_i.ld_error || cmd_i.ld_empty) begin
      out_valid_q <= 1'b1;
      has_data_q  <= 1'b0;
      status_q    <= cmd_i.ld_error;
      last_q      <= 1'b1;
      out_len_q   <= '0;
    end else if (cmd_i.emit_byte) begin
      out_valid_q <= 1'b1;
      has_data_q  <= 1'b1;
      status_q    <= 1'b0;
      last_q      <= sts_o.idx_last;
      out_len_q   <= len_q;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = has_data_q ? rd_q : '0;
  assign has_data_o       = has_data_q;
  assign status_o         = status_q;
  assign payload_length_o = out_len_q;
  assign last_o           = last_q;

  // a new result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_byte || cmd_i.ld_error || cmd_i.ld_empty) |-> out_free)
    else $error("result loaded over a pending word");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_byte |-> (idx_q < len_q))
    else $error("read index beyond delivered length");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CNT_W'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_data_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_data_o) |-> (!status_o && payload_length_o != '0))
    else $error("data word with error status or zero length");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_error |=> (out_valid_o && status_o && last_o && !has_data_o))
    else $error("mismatch result malformed");

endmodule
